// ===== rtl/core/byte_stuffed_frame_receiver_defines.svh =====
// Assertion macros for the byte-stuffed frame receiver.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef BYTE_STUFFED_FRAME_RECEIVER_DEFINES_SVH
`define BYTE_STUFFED_FRAME_RECEIVER_DEFINES_SVH

`ifndef SYNTHESIS

// Checked outside reset.
`define BSFR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define BSFR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define BSFR_ASSERT(lbl, prop, msg)
`define BSFR_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== rtl/core/bsfr_pkg.sv =====
// Shared types and constants of the byte-stuffed frame receiver.
// No dependencies; used by bsfr_decode, the top level and the testbench.
package bsfr_pkg;

    localparam logic [7:0] START_BYTE = 8'hFB;
    localparam logic [7:0] END_BYTE   = 8'hFE;
    localparam logic [7:0] ESC_BYTE   = 8'hFC;
    localparam logic [7:0] ESC_START  = 8'hCB;
    localparam logic [7:0] ESC_END    = 8'hCE;

    localparam logic [12:0] MAX_FRAME_RESET = 13'd1024;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [2:0] ERR_NONE          = 3'd0;
    localparam logic [2:0] ERR_START_IN_BODY = 3'd1;
    localparam logic [2:0] ERR_BAD_ESCAPE    = 3'd2;
    localparam logic [2:0] ERR_OVERFLOW      = 3'd3;
    localparam logic [2:0] ERR_TOO_SHORT     = 3'd4;

    typedef enum logic [1:0] {
        MODE_HUNT   = 2'd0,
        MODE_BODY   = 2'd1,
        MODE_ESCAPE = 2'd2
    } t_mode;

    // Deframer state; held_old is the older of the two delayed bytes.
    typedef struct packed {
        t_mode       mode;
        logic [7:0]  held_old;
        logic [7:0]  held_new;
        logic [1:0]  held_count;
        logic [12:0] frame_count;
    } t_state;

    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [11:0] payload_length;
        logic [2:0]  error_code;
    } t_result;

endpackage

// ===== rtl/core/bsfr_if.sv =====
// Channel interfaces of the byte-stuffed frame receiver: raw bytes in,
// results out, and the max_frame_bytes write port. Depends on nothing.
interface bsfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface bsfr_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [11:0] payload_length;
    logic [2:0]  error_code;

    modport source (output valid, output kind, output data_byte,
                    output payload_length, output error_code, input ready);
    modport sink   (input valid, input kind, input data_byte,
                    input payload_length, input error_code, output ready);
endinterface

interface bsfr_cfg_if;
    logic        valid;
    logic        ready;
    logic [12:0] max_frame_bytes;

    modport source (output valid, output max_frame_bytes, input ready);
    modport sink   (input valid, input max_frame_bytes, output ready);
endinterface

// ===== rtl/core/byte_stuffed_frame_receiver.sv =====
// Top level of the byte-stuffed frame receiver (start FB, escape FC, end FE).
// Depends on bsfr_pkg, the bsfr_*_if interfaces, bsfr_decode and the defines header.
//
//  channel  | dir | payload                                         | beat
//  ---------+-----+-------------------------------------------------+-------------------
//  i_in     | in  | in_byte[7:0]                                    | one raw link byte
//  o_out    | out | kind[1:0] data_byte[7:0] payload_length[11:0]   | one result
//           |     | error_code[2:0]                                 |
//  i_cfg    | in  | max_frame_bytes[12:0]                           | register write
//
// One byte per clock sustained while o_out is not stalled. A byte is held in the input
// register, decoded against the frame state, and its result (if any) is registered in
// the output register when the input stage advances.
// Reset (synchronous, active low) returns to hunting, empties both registers
// and sets max_frame_bytes to 1024. A stall on o_out holds the input stage;
// bytes that give no result still pass while an earlier result waits.
// i_cfg is always ready.
`include "byte_stuffed_frame_receiver_defines.svh"

module byte_stuffed_frame_receiver (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bsfr_in_if.sink           i_in,
    bsfr_out_if.source        o_out,
    bsfr_cfg_if.sink          i_cfg
);

    // input register
    logic              r_s1_valid;
    logic [7:0]        r_s1_byte;

    // frame state and limit
    bsfr_pkg::t_state  r_state;
    bsfr_pkg::t_state  n_state;
    logic [12:0]       r_max_frame;

    // result register
    logic              r_out_valid;
    bsfr_pkg::t_result r_out;

    bsfr_pkg::t_result w_res;
    logic              w_out_free;
    logic              w_s1_adv;
    logic              w_s1_free;

    bsfr_decode u_decode (
        .i_state     (r_state),
        .i_byte      (r_s1_byte),
        .i_max_frame (r_max_frame),
        .o_state     (n_state),
        .o_result    (w_res)
    );

    // A decoded byte with no result never needs the output register.
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_s1_adv   = r_s1_valid && (w_out_free || !w_res.valid);
    assign w_s1_free  = !r_s1_valid || w_s1_adv;

    assign i_in.ready  = w_s1_free;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_free) begin
            r_s1_valid <= i_in.valid;
        end
        if (w_s1_free && i_in.valid) begin
            r_s1_byte <= i_in.in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_max_frame <= bsfr_pkg::MAX_FRAME_RESET;
        end else begin
            if (w_s1_adv) begin
                r_state <= n_state;
            end
            if (i_cfg.valid) begin
                r_max_frame <= i_cfg.max_frame_bytes;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_s1_adv && w_res.valid;
        end
        if (w_out_free && w_s1_adv && w_res.valid) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.kind           = r_out.kind;
    assign o_out.data_byte      = r_out.data_byte;
    assign o_out.payload_length = r_out.payload_length;
    assign o_out.error_code     = r_out.error_code;

    // delay line never holds more than two bytes
    `BSFR_ASSERT(a_held_count_max, r_state.held_count != 2'd3, "held_count above two")

    // error results carry a code, other results none
    `BSFR_ASSERT(a_err_code_kind, r_out_valid |-> ((r_out.kind == bsfr_pkg::KIND_ERROR) == (r_out.error_code != bsfr_pkg::ERR_NONE)), "error code does not match kind")

    // a new result only enters when the previous one left or was absent
    `BSFR_ASSERT(a_no_overwrite, (r_out_valid && !o_out.ready) |=> (r_out_valid && $stable(r_out)), "pending result overwritten")

    // reset leaves the block hunting with nothing pending
    `BSFR_ASSERT_ALWAYS(a_reset_state, !i_rst_n |=> (r_state.mode == bsfr_pkg::MODE_HUNT && !r_out_valid && !r_s1_valid), "state after reset")

endmodule

// ===== rtl/core/bsfr_decode.sv =====
// Per-beat decode: next deframer state and optional result from one byte.
// Purely combinational; depends on bsfr_pkg.
module bsfr_decode (
    input  bsfr_pkg::t_state  i_state,
    input  logic [7:0]        i_byte,
    input  logic [12:0]       i_max_frame,
    output bsfr_pkg::t_state  o_state,
    output bsfr_pkg::t_result o_result
);

    always_comb begin
        logic        store_en;
        logic [7:0]  store_val;
        logic [12:0] fc_inc;
        logic [12:0] len_full;
        logic        full;

        o_state   = i_state;
        o_result  = '0;
        store_en  = 1'b0;
        store_val = i_byte;
        fc_inc    = i_state.frame_count + 13'd1;
        len_full  = i_state.frame_count - 13'd2;
        full      = (i_state.held_count == 2'd2);

        case (i_state.mode)
            bsfr_pkg::MODE_BODY: begin
                if (i_byte == bsfr_pkg::ESC_BYTE) begin
                    o_state.mode = bsfr_pkg::MODE_ESCAPE;
                end else if (i_byte == bsfr_pkg::START_BYTE) begin
                    o_state.mode        = bsfr_pkg::MODE_HUNT;
                    o_result.valid      = 1'b1;
                    o_result.kind       = bsfr_pkg::KIND_ERROR;
                    o_result.error_code = bsfr_pkg::ERR_START_IN_BODY;
                end else if (i_byte == bsfr_pkg::END_BYTE) begin
                    o_state.mode   = bsfr_pkg::MODE_HUNT;
                    o_result.valid = 1'b1;
                    if (i_state.frame_count < 13'd2) begin
                        o_result.kind       = bsfr_pkg::KIND_ERROR;
                        o_result.error_code = bsfr_pkg::ERR_TOO_SHORT;
                    end else begin
                        o_result.kind           = bsfr_pkg::KIND_END;
                        // saturate to 12 bits
                        o_result.payload_length = len_full[12] ? 12'hFFF : len_full[11:0];
                    end
                end else begin
                    store_en = 1'b1;
                end
            end
            bsfr_pkg::MODE_ESCAPE: begin
                case (i_byte)
                    bsfr_pkg::ESC_START: begin
                        store_en  = 1'b1;
                        store_val = bsfr_pkg::START_BYTE;
                    end
                    bsfr_pkg::ESC_END: begin
                        store_en  = 1'b1;
                        store_val = bsfr_pkg::END_BYTE;
                    end
                    bsfr_pkg::ESC_BYTE: begin
                        store_en  = 1'b1;
                        store_val = bsfr_pkg::ESC_BYTE;
                    end
                    default: begin
                        o_state.mode        = bsfr_pkg::MODE_HUNT;
                        o_result.valid      = 1'b1;
                        o_result.kind       = bsfr_pkg::KIND_ERROR;
                        o_result.error_code = bsfr_pkg::ERR_BAD_ESCAPE;
                    end
                endcase
            end
            bsfr_pkg::MODE_HUNT: begin
                if (i_byte == bsfr_pkg::START_BYTE) begin
                    o_state.mode        = bsfr_pkg::MODE_BODY;
                    o_state.frame_count = '0;
                    o_state.held_count  = '0;
                    o_state.held_old    = '0;
                    o_state.held_new    = '0;
                end
            end
            default: begin
                o_state.mode = bsfr_pkg::MODE_HUNT;
            end
        endcase

        // Two-byte delay line: a plain shift; the older entry leaves once full.
        if (store_en) begin
            o_state.held_old    = i_state.held_new;
            o_state.held_new    = store_val;
            o_state.held_count  = full ? 2'd2 : i_state.held_count + 2'd1;
            o_state.frame_count = fc_inc;
            o_state.mode        = bsfr_pkg::MODE_BODY;
            if (fc_inc >= i_max_frame) begin
                o_state.mode        = bsfr_pkg::MODE_HUNT;
                o_result.valid      = 1'b1;
                o_result.kind       = bsfr_pkg::KIND_ERROR;
                o_result.error_code = bsfr_pkg::ERR_OVERFLOW;
            end else if (full) begin
                o_result.valid     = 1'b1;
                o_result.kind      = bsfr_pkg::KIND_DATA;
                o_result.data_byte = i_state.held_old;
            end
        end
    end

endmodule

// ===== verif/tb_top.sv =====
// Testbench for byte_stuffed_frame_receiver: drives raw link bytes, checks every result beat
// against the deframer predictor or a table row. Depends on bsfr_pkg, bsfr_*_if and the RTL.
module tb_top;
    import bsfr_pkg::*;

    localparam int unsigned FLUSH_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES  = 150;  // long sink hold-off
    localparam int unsigned RAND_ITEMS   = 370;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [11:0] payload_length;
        logic [2:0]  error_code;
    } t_beat;

    // How a row of the directed table is checked.
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_TYPED} t_row_chk;

    typedef struct packed {
        t_row_chk   chk;
        logic [7:0] link_byte;
        t_beat      res;
    } t_row;

    typedef enum logic [2:0] {
        FLAW_NONE, FLAW_START, FLAW_ESCAPE, FLAW_NOISE, FLAW_NO_END
    } t_flaw;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bsfr_in_if  in_if();
    bsfr_out_if out_if();
    bsfr_cfg_if cfg_if();

    byte_stuffed_frame_receiver i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always #5 i_clk = ~i_clk;

    // Deframer state as the predictor sees it.
    t_mode       rx_mode;
    logic [7:0]  held_old;
    logic [7:0]  held_new;
    logic [1:0]  held_cnt;
    logic [12:0] frame_cnt;
    logic [12:0] max_frame;

    t_beat       pending_results[$];
    t_row        dir_rows[$];
    int unsigned mismatch_cnt;
    int unsigned live_items;   // bytes the deframer acts on
    bit          src_burst;    // sender offers back to back
    bit          hold_req;

    function automatic t_beat mk_beat(input logic [1:0] kind, input logic [7:0] data,
                                      input logic [11:0] len, input logic [2:0] err);
        t_beat r;
        r.kind           = kind;
        r.data_byte      = data;
        r.payload_length = len;
        r.error_code     = err;
        return r;
    endfunction

    function automatic void add_row(input t_row_chk chk, input logic [7:0] b,
                                    input t_beat res = '0);
        t_row r;
        r.chk       = chk;
        r.link_byte = b;
        r.res       = res;
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Decoded byte into the two-deep delay line; the oldest one leaves once it is full.
    function automatic void hold_decoded(input logic [7:0] d, output bit got,
                                         output t_beat r);
        logic [7:0] oldest;
        bit         full;
        oldest = held_old;
        full   = (held_cnt >= 2'd2);
        if (full) begin
            held_old = held_new;
            held_new = d;
        end else begin
            if (held_cnt == 2'd0) held_old = d;
            else held_new = d;
            held_cnt = held_cnt + 2'd1;
        end
        frame_cnt = frame_cnt + 13'd1;
        rx_mode   = MODE_BODY;
        got       = 1'b0;
        r         = '0;
        if (frame_cnt >= max_frame) begin
            rx_mode = MODE_HUNT;
            got     = 1'b1;
            r       = mk_beat(KIND_ERROR, 8'h00, 12'd0, ERR_OVERFLOW);
        end else if (full) begin
            got = 1'b1;
            r   = mk_beat(KIND_DATA, oldest, 12'd0, ERR_NONE);
        end
    endfunction

    function automatic void deframe_byte(input logic [7:0] b, output bit got,
                                         output t_beat r);
        logic [12:0] body_len;
        got = 1'b0;
        r   = '0;
        case (rx_mode)
            MODE_BODY: begin
                if (b == ESC_BYTE) begin
                    rx_mode = MODE_ESCAPE;
                end else if (b == START_BYTE) begin
                    rx_mode = MODE_HUNT;
                    got     = 1'b1;
                    r       = mk_beat(KIND_ERROR, 8'h00, 12'd0, ERR_START_IN_BODY);
                end else if (b == END_BYTE) begin
                    got     = 1'b1;
                    rx_mode = MODE_HUNT;
                    if (frame_cnt < 13'd2) begin
                        r = mk_beat(KIND_ERROR, 8'h00, 12'd0, ERR_TOO_SHORT);
                    end else begin
                        // check bytes dropped; length saturates at 12 bits
                        body_len = frame_cnt - 13'd2;
                        r = mk_beat(KIND_END, 8'h00,
                                    (body_len > 13'd4095) ? 12'hFFF : body_len[11:0],
                                    ERR_NONE);
                    end
                end else begin
                    hold_decoded(b, got, r);
                end
            end
            MODE_ESCAPE: begin
                if (b == ESC_START) hold_decoded(START_BYTE, got, r);
                else if (b == ESC_END) hold_decoded(END_BYTE, got, r);
                else if (b == ESC_BYTE) hold_decoded(ESC_BYTE, got, r);
                else begin
                    rx_mode = MODE_HUNT;
                    got     = 1'b1;
                    r       = mk_beat(KIND_ERROR, 8'h00, 12'd0, ERR_BAD_ESCAPE);
                end
            end
            default: begin
                if (b == START_BYTE) begin
                    rx_mode   = MODE_BODY;
                    frame_cnt = '0;
                    held_cnt  = '0;
                    held_old  = '0;
                    held_new  = '0;
                end
            end
        endcase
    endfunction

    // One link byte; called at a rising edge, returns at the edge that accepts it.
    task automatic send_link_byte(input logic [7:0] b, input t_row_chk chk = CHK_MODEL,
                                  input t_beat typed = '0);
        int unsigned gap;
        bit          got;
        t_beat       res;
        gap = src_burst ? 0 : pick_gap();
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.in_byte <= b;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        if (rx_mode != MODE_HUNT || b == START_BYTE) live_items++;
        deframe_byte(b, got, res);
        case (chk)
            CHK_TYPED: pending_results.insert(pending_results.size(), typed);
            CHK_MODEL: if (got) pending_results.insert(pending_results.size(), res);
            default: ;
        endcase
    endtask

    // Start byte, n decoded bytes with stuffing, end byte; optionally one flaw.
    task automatic send_frame(input int unsigned n_bytes, input t_flaw flaw);
        int unsigned flaw_at;
        logic [7:0]  d;
        logic [7:0]  bad;
        flaw_at = $urandom_range(0, n_bytes);
        send_link_byte(START_BYTE);
        for (int unsigned i = 0; i <= n_bytes; i++) begin
            if (i == flaw_at) begin
                case (flaw)
                    FLAW_START: send_link_byte(START_BYTE);
                    FLAW_NOISE: send_link_byte(8'($urandom_range(0, 255)));
                    FLAW_ESCAPE: begin
                        do bad = 8'($urandom_range(0, 255));
                        while (bad == ESC_START || bad == ESC_END || bad == ESC_BYTE);
                        send_link_byte(ESC_BYTE);
                        send_link_byte(bad);
                    end
                    default: ;
                endcase
            end
            if (i < n_bytes) begin
                // lean on the special codes so escapes show up often
                if ($urandom_range(0, 3) == 0) begin
                    case ($urandom_range(0, 4))
                        0: d = START_BYTE;
                        1: d = END_BYTE;
                        2: d = ESC_BYTE;
                        3: d = ESC_START;
                        default: d = ESC_END;
                    endcase
                end else begin
                    d = 8'($urandom_range(0, 255));
                end
                case (d)
                    START_BYTE: begin
                        send_link_byte(ESC_BYTE);
                        send_link_byte(ESC_START);
                    end
                    END_BYTE: begin
                        send_link_byte(ESC_BYTE);
                        send_link_byte(ESC_END);
                    end
                    ESC_BYTE: begin
                        send_link_byte(ESC_BYTE);
                        send_link_byte(ESC_BYTE);
                    end
                    default: send_link_byte(d);
                endcase
            end
        end
        if (flaw != FLAW_NO_END) send_link_byte(END_BYTE);
    endtask

    // Sender pauses until every expected beat is back and the pipe is empty.
    task automatic wait_flushed();
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (FLUSH_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_max_frame(input logic [12:0] v);
        wait_flushed();
        cfg_if.valid           <= 1'b1;
        cfg_if.max_frame_bytes <= v;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        max_frame = v;
        cfg_if.valid <= 1'b0;
    endtask

    // Result sink: random stalls, calm stretches, and one long hold-off on request.
    initial begin
        int unsigned stall_left;
        int unsigned calm_left;
        stall_left = 0;
        calm_left  = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            if (stall_left != 0) begin
                out_if.ready <= 1'b0;
                stall_left--;
            end else begin
                out_if.ready <= 1'b1;
                if (calm_left != 0) calm_left--;
                else if ($urandom_range(0, 99) < 3) calm_left = $urandom_range(50, 200);
                else stall_left = pick_gap();
            end
        end
    end

    // Each accepted result beat against the oldest expectation.
    always @(posedge i_clk) begin
        t_beat want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_results.size() == 0) begin
                if (mismatch_cnt < 10)
                    $display("unexpected beat: kind=%0d data=%02h len=%0d err=%0d",
                             out_if.kind, out_if.data_byte, out_if.payload_length,
                             out_if.error_code);
                mismatch_cnt++;
            end else begin
                want = pending_results.pop_front();
                if (out_if.kind !== want.kind || out_if.data_byte !== want.data_byte ||
                    out_if.payload_length !== want.payload_length ||
                    out_if.error_code !== want.error_code) begin
                    if (mismatch_cnt < 10)
                        $display("mismatch: exp kind=%0d data=%02h len=%0d err=%0d, got kind=%0d data=%02h len=%0d err=%0d",
                                 want.kind, want.data_byte, want.payload_length,
                                 want.error_code, out_if.kind, out_if.data_byte,
                                 out_if.payload_length, out_if.error_code);
                    mismatch_cnt++;
                end
            end
        end
    end

    initial begin
        #20000000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int unsigned next_cfg_at;
        int unsigned pick;
        i_rst_n                <= 1'b0;
        in_if.valid            <= 1'b0;
        in_if.in_byte          <= 8'h00;
        cfg_if.valid           <= 1'b0;
        cfg_if.max_frame_bytes <= '0;
        rx_mode      = MODE_HUNT;
        held_old     = '0;
        held_new     = '0;
        held_cnt     = '0;
        frame_cnt    = '0;
        max_frame    = MAX_FRAME_RESET;
        mismatch_cnt = 0;
        live_items   = 0;
        src_burst    = 1'b0;
        hold_req     = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table at the reset limit: hunting noise, escapes, each error but overflow.
        add_row(CHK_NONE, 8'h00);
        add_row(CHK_NONE, 8'hFF);
        add_row(CHK_NONE, START_BYTE);
        add_row(CHK_TYPED, END_BYTE, mk_beat(KIND_ERROR, 8'h00, 12'd0, ERR_TOO_SHORT));
        add_row(CHK_NONE, START_BYTE);
        add_row(CHK_NONE, 8'h00);
        add_row(CHK_NONE, 8'hFF);
        add_row(CHK_NONE, ESC_BYTE);
        add_row(CHK_TYPED, ESC_START, mk_beat(KIND_DATA, 8'h00, 12'd0, ERR_NONE));
        add_row(CHK_NONE, ESC_BYTE);
        add_row(CHK_TYPED, ESC_END, mk_beat(KIND_DATA, 8'hFF, 12'd0, ERR_NONE));
        add_row(CHK_NONE, ESC_BYTE);
        add_row(CHK_MODEL, ESC_BYTE);
        add_row(CHK_TYPED, END_BYTE, mk_beat(KIND_END, 8'h00, 12'd3, ERR_NONE));
        add_row(CHK_NONE, START_BYTE);
        add_row(CHK_NONE, 8'h41);
        add_row(CHK_TYPED, START_BYTE,
                mk_beat(KIND_ERROR, 8'h00, 12'd0, ERR_START_IN_BODY));
        add_row(CHK_NONE, START_BYTE);
        add_row(CHK_NONE, ESC_BYTE);
        add_row(CHK_TYPED, 8'h00, mk_beat(KIND_ERROR, 8'h00, 12'd0, ERR_BAD_ESCAPE));
        add_row(CHK_NONE, START_BYTE);
        add_row(CHK_NONE, ESC_BYTE);
        add_row(CHK_TYPED, START_BYTE, mk_beat(KIND_ERROR, 8'h00, 12'd0, ERR_BAD_ESCAPE));
        add_row(CHK_NONE, START_BYTE);
        add_row(CHK_NONE, 8'h12);
        add_row(CHK_MODEL, 8'h34);
        add_row(CHK_TYPED, END_BYTE, mk_beat(KIND_END, 8'h00, 12'd0, ERR_NONE));
        foreach (dir_rows[i])
            send_link_byte(dir_rows[i].link_byte, dir_rows[i].chk, dir_rows[i].res);

        // Limit extremes: tiny limits overflow on the first or second byte.
        write_max_frame(13'd2);
        send_frame(1, FLAW_NONE);
        send_frame(2, FLAW_NONE);
        write_max_frame(13'd0);
        send_frame(1, FLAW_NONE);
        write_max_frame(13'd1);
        send_frame(1, FLAW_NONE);

        // A large limit (4096), with a long sink hold-off under a back-to-back burst.
        src_burst = 1'b1;
        write_max_frame(13'd4096);
        hold_req = 1'b1;   // sink holds off while the sender keeps offering
        send_frame(30, FLAW_NONE);
        src_burst = 1'b0;

        // Random part: mostly clean frames, some broken, some line noise.
        live_items  = 0;
        next_cfg_at = 70;
        write_max_frame(MAX_FRAME_RESET);
        while (live_items < RAND_ITEMS) begin
            if (live_items >= next_cfg_at) begin
                next_cfg_at = live_items + $urandom_range(50, 90);
                pick = $urandom_range(0, 9);
                if (pick < 4) write_max_frame(MAX_FRAME_RESET);
                else if (pick < 8) write_max_frame(13'($urandom_range(2, 30)));
                else write_max_frame(13'($urandom_range(31, 300)));
            end
            src_burst = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                send_frame(($urandom_range(0, 99) < 85) ? $urandom_range(0, 12)
                                                        : $urandom_range(13, 48),
                           FLAW_NONE);
            end else if (pick < 88) begin
                send_frame($urandom_range(0, 12), t_flaw'($urandom_range(1, 4)));
            end else begin
                repeat ($urandom_range(1, 6)) send_link_byte(8'($urandom_range(0, 255)));
            end
        end

        wait_flushed();
        if (mismatch_cnt == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
